[rtl/oab_pkg.sv]
// Shared types and constants for the OID arc base-128 encoder.
`default_nettype none

package oab_pkg;

  localparam int ARC_IN_W      = 32;  // width of the arc port
  localparam int DEF_ARC_BITS  = 32;
  localparam int DEF_CMD_DEPTH = 4;
  localparam int GROUP_W       = 7;
  localparam int MAX_GROUPS    = 5;
  localparam int GRP_BITS      = GROUP_W * MAX_GROUPS;
  localparam int GRP_IDX_W     = 3;
  localparam int MAX_FIRST_ARC = 2;
  localparam int FIRST_MULT    = 40;

  localparam logic [7:0] CONT_BIT   = 8'h80;
  localparam logic [7:0] GROUP_MASK = 8'h7f;

  typedef enum logic [1:0] {
    POS_FIRST   = 2'd0,
    POS_SECOND  = 2'd1,
    POS_BODY    = 2'd2,
    POS_DISCARD = 2'd3
  } arc_pos_t;

  // Control part of one request handed from the front to the back.
  typedef struct packed {
    logic                 bad;
    logic [GRP_IDX_W-1:0] top;  // index of the most significant group
  } cmd_ctl_t;

endpackage

`default_nettype wire

[rtl/oab_front.sv]
// Front end: tracks the arc position, forms the value and group count of each arc.
`default_nettype none

module oab_front
  import oab_pkg::*;
#(
  parameter int ARC_BITS = DEF_ARC_BITS,
  parameter int VAL_W    = ((ARC_BITS < ARC_IN_W) ? ARC_BITS : ARC_IN_W) + 1
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                take,
  input  wire logic [ARC_IN_W-1:0] arc_value,
  input  wire logic                first_of_oid,
  input  wire logic                last_of_oid,
  output logic                     cmd_push,
  output logic [VAL_W-1:0]         cmd_val,
  output cmd_ctl_t                 cmd_ctl
);

  localparam int KEEP_W = (ARC_BITS < ARC_IN_W) ? ARC_BITS : ARC_IN_W;

  arc_pos_t    pos, pos_next;
  logic [1:0]  held, held_next;

  logic [KEEP_W-1:0]   kept;
  logic [VAL_W-1:0]    arc_ext;
  logic [VAL_W-1:0]    first_scaled;
  logic [GRP_BITS-1:0] val_wide;
  logic                take_first;
  logic                too_big;

  assign kept         = arc_value[KEEP_W-1:0];
  assign arc_ext      = VAL_W'(kept);
  assign take_first   = first_of_oid || (pos == POS_FIRST);
  assign too_big      = kept > KEEP_W'(MAX_FIRST_ARC);
  // held * 40 as 32*held + 8*held
  assign first_scaled = VAL_W'({held, 5'b0}) + VAL_W'({held, 3'b0});

  always_comb begin
    pos_next = pos;
    if (take) begin
      if (take_first) begin
        if (too_big) begin
          pos_next = last_of_oid ? POS_FIRST : POS_DISCARD;
        end else begin
          pos_next = last_of_oid ? POS_FIRST : POS_SECOND;
        end
      end else if (pos == POS_DISCARD) begin
        if (last_of_oid) begin
          pos_next = POS_FIRST;
        end
      end else begin
        pos_next = last_of_oid ? POS_FIRST : POS_BODY;
      end
    end
  end

  always_comb begin
    held_next   = held;
    cmd_push    = 1'b0;
    cmd_ctl.bad = 1'b0;
    cmd_ctl.top = '0;
    cmd_val     = (pos == POS_SECOND) ? (first_scaled + arc_ext) : arc_ext;
    val_wide    = GRP_BITS'(cmd_val);
    for (int i = 1; i < MAX_GROUPS; i++) begin
      if ((val_wide >> (GROUP_W * i)) != '0) begin
        cmd_ctl.top = GRP_IDX_W'(i);
      end
    end
    if (take) begin
      case (1'b1)
        take_first: begin
          if (too_big || last_of_oid) begin
            held_next   = 2'd0;
            cmd_push    = 1'b1;
            cmd_ctl.bad = 1'b1;
          end else begin
            held_next = kept[1:0];
          end
        end
        (pos == POS_DISCARD): begin
          held_next = held;
        end
        default: begin
          cmd_push = 1'b1;
          if (last_of_oid) begin
            held_next = 2'd0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= POS_FIRST;
      held <= 2'd0;
    end else begin
      pos  <= pos_next;
      held <= held_next;
    end
  end

endmodule

`default_nettype wire

[rtl/oab_cmd_fifo.sv]
// Short request queue between the front end and the byte emitter.
`default_nettype none

module oab_cmd_fifo
  import oab_pkg::*;
#(
  parameter int VAL_W = DEF_ARC_BITS + 1,
  parameter int DEPTH = DEF_CMD_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       wr,
  input  wire logic [VAL_W-1:0] wr_val,
  input  wire cmd_ctl_t   wr_ctl,
  input  wire logic       rd,
  output logic [VAL_W-1:0] rd_val,
  output cmd_ctl_t        rd_ctl,
  output logic            fifo_full,
  output logic            fifo_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [VAL_W-1:0] val_mem [DEPTH];
  cmd_ctl_t         ctl_mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign fifo_full  = count == (PTR_W + 1)'(DEPTH);
  assign fifo_empty = count == '0;
  assign rd_val     = val_mem[rd_ptr];
  assign rd_ctl     = ctl_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      val_mem[wr_ptr] <= wr_val;
      ctl_mem[wr_ptr] <= wr_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (PTR_W + 1)'(wr) - (PTR_W + 1)'(rd);
    end
  end

endmodule

`default_nettype wire

[rtl/oab_back.sv]
// Back end: emits one 7-bit group per cycle into the output register while it is empty or popped.
`default_nettype none

module oab_back
  import oab_pkg::*;
#(
  parameter int VAL_W = DEF_ARC_BITS + 1
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [VAL_W-1:0] cmd_val,
  input  wire cmd_ctl_t         cmd_ctl,
  input  wire logic             cmd_empty,
  output logic                  cmd_pop,
  input  wire logic             pop,
  output logic                  empty,
  output logic [7:0]            out_byte,
  output logic                  arc_done,
  output logic                  bad_oid
);

  logic                 busy;
  logic                 out_valid;
  logic [GRP_BITS-1:0]  cur_val;
  logic [GRP_IDX_W-1:0] cur_n;
  logic                 cur_bad;

  logic                 out_ready;
  logic                 emit;
  logic                 finish;
  logic [GRP_BITS-1:0]  shifted;
  logic [7:0]           grp_byte;

  assign out_ready = !out_valid || pop;
  assign emit      = busy && out_ready;
  assign finish    = emit && (cur_bad || (cur_n == '0));
  assign cmd_pop   = (!busy || finish) && !cmd_empty;
  assign empty     = !out_valid;

  assign shifted  = cur_val >> (GROUP_W * cur_n);
  assign grp_byte = (8'(shifted[GROUP_W-1:0]) & GROUP_MASK)
                  | ((cur_n != '0) ? CONT_BIT : 8'h00);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd_pop) begin
        busy <= 1'b1;
      end else if (finish) begin
        busy <= 1'b0;
      end
      if (out_ready) begin
        out_valid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur_val <= GRP_BITS'(cmd_val);
      cur_n   <= cmd_ctl.top;
      cur_bad <= cmd_ctl.bad;
    end else if (emit && !finish) begin
      cur_n <= cur_n - 1'b1;
    end
    if (emit) begin
      // an error request carries a zero byte and no done mark
      out_byte <= cur_bad ? 8'h00 : grp_byte;
      arc_done <= !cur_bad && (cur_n == '0);
      bad_oid  <= cur_bad;
    end
  end

endmodule

`default_nettype wire

[rtl/oid_arc_base128_encoder_top.sv]
// An arc's first byte passes the request queue, the emitter's request register and the output
// register. Throughput: one arc per cycle in while not full; results leave the group emitter
// at one byte per cycle unless pop stalls them: an arc gives 1 to 5 bytes (its group count), an
// error one, a held first or discarded arc none. The request queue absorbs bursts in between.
// Reset (rst, synchronous) returns to expecting a first arc and empties the queue and output.
`default_nettype none

module oid_arc_base128_encoder_top
  import oab_pkg::*;
#(
  parameter int ARC_BITS  = DEF_ARC_BITS,
  parameter int CMD_DEPTH = DEF_CMD_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  output logic                     full,
  input  wire logic [ARC_IN_W-1:0] arc_value,
  input  wire logic                first_of_oid,
  input  wire logic                last_of_oid,
  input  wire logic                pop,
  output logic                     empty,
  output logic [7:0]               out_byte,
  output logic                     arc_done,
  output logic                     bad_oid
);

  localparam int VAL_W = ((ARC_BITS < ARC_IN_W) ? ARC_BITS : ARC_IN_W) + 1;

  logic             take;
  logic             cmd_push;
  logic [VAL_W-1:0] cmd_val;
  cmd_ctl_t         cmd_ctl;
  logic             cmd_pop;
  logic [VAL_W-1:0] head_val;
  cmd_ctl_t         head_ctl;
  logic             cmd_empty;

  assign take = push && !full;

  oab_front #(
    .ARC_BITS (ARC_BITS),
    .VAL_W    (VAL_W)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .arc_value    (arc_value),
    .first_of_oid (first_of_oid),
    .last_of_oid  (last_of_oid),
    .cmd_push     (cmd_push),
    .cmd_val      (cmd_val),
    .cmd_ctl      (cmd_ctl)
  );

  oab_cmd_fifo #(
    .VAL_W (VAL_W),
    .DEPTH (CMD_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .wr         (cmd_push),
    .wr_val     (cmd_val),
    .wr_ctl     (cmd_ctl),
    .rd         (cmd_pop),
    .rd_val     (head_val),
    .rd_ctl     (head_ctl),
    .fifo_full  (full),
    .fifo_empty (cmd_empty)
  );

  oab_back #(
    .VAL_W (VAL_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_val   (head_val),
    .cmd_ctl   (head_ctl),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .pop       (pop),
    .empty     (empty),
    .out_byte  (out_byte),
    .arc_done  (arc_done),
    .bad_oid   (bad_oid)
  );

endmodule

`default_nettype wire

[tb/tb_oid_arc_base128_encoder_top.sv]
// Self-checking testbench for the OID arc base-128 encoder: directed table plus random OIDs.
module tb_oid_arc_base128_encoder_top;
  timeunit 1ns;
  timeprecision 1ps;

  import oab_pkg::*;

  localparam int  N_RANDOM     = 75;
  localparam int  DRAIN_CYCLES = 20;
  localparam logic CHK_TYPED   = 1'b1;
  localparam logic CHK_PREDICT = 1'b0;

  // One encoded byte as it leaves the block.
  typedef struct packed {
    logic [7:0] data;
    logic       done;
    logic       bad;
  } oid_byte_t;

  // One row of the directed table; bytes holds the typed encoding, first byte leftmost.
  typedef struct packed {
    logic [31:0] arc;
    logic        first;
    logic        last;
    logic        typed;
    logic [2:0]  cnt;
    logic        bad;
    logic [39:0] bytes;
  } arc_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                push = 1'b0;
  logic                full;
  logic [ARC_IN_W-1:0] arc_value = '0;
  logic                first_of_oid = 1'b0;
  logic                last_of_oid = 1'b0;
  logic                pop = 1'b0;
  logic                empty;
  logic [7:0]          out_byte;
  logic                arc_done;
  logic                bad_oid;

  // Row data that travels with the request so the monitor can pick it up on acceptance.
  logic        row_typed = 1'b0;
  logic [2:0]  row_cnt = '0;
  logic        row_bad = 1'b0;
  logic [39:0] row_bytes = '0;

  oid_byte_t  oid_bytes_q[$];
  oid_byte_t  arc_bytes_q[$];
  arc_row_t   dir_tab[$];
  arc_pos_t   enc_pos;
  logic [1:0] enc_first;

  int  n_mismatch = 0;
  int  n_sent = 0;
  int  n_bytes = 0;
  int  n_errors = 0;
  int  rx_hold = 0;
  bit  rx_quiet = 1'b0;
  bit  tx_quiet = 1'b0;

  oid_arc_base128_encoder_top u_top (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .arc_value    (arc_value),
    .first_of_oid (first_of_oid),
    .last_of_oid  (last_of_oid),
    .pop          (pop),
    .empty        (empty),
    .out_byte     (out_byte),
    .arc_done     (arc_done),
    .bad_oid      (bad_oid)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $realtime, msg);
    n_mismatch++;
  endtask

  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(12, 30);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [31:0] rand_arc();
    int w;
    w = $urandom_range(1, 32);
    case ($urandom_range(0, 7))
      0: return 32'hFFFF_FFFF;
      1: return 32'd1 << (GROUP_W * $urandom_range(1, 4));
      2: return (32'd1 << (GROUP_W * $urandom_range(1, 4))) - 32'd1;
      3: return '0;
      default: return $urandom >> (32 - w);
    endcase
  endfunction

  // Encode one arc into arc_bytes_q and advance the OID position.
  task automatic encode_arc(input logic [31:0] arc, input logic f, input logic l);
    logic [63:0] val;
    logic [7:0]  grp;
    int          n;
    val = {32'd0, arc};
    if (f || enc_pos == POS_FIRST) begin
      if (arc > MAX_FIRST_ARC || l) begin
        enc_first = '0;
        enc_pos = (l || arc <= MAX_FIRST_ARC) ? POS_FIRST : POS_DISCARD;
        arc_bytes_q.insert(arc_bytes_q.size(), oid_byte_t'{8'h00, 1'b0, 1'b1});
      end else begin
        enc_first = arc[1:0];
        enc_pos = POS_SECOND;
      end
    end else if (enc_pos == POS_DISCARD) begin
      if (l) enc_pos = POS_FIRST;
    end else begin
      if (enc_pos == POS_SECOND) val = enc_first * FIRST_MULT + val;
      n = 1;
      while (n < MAX_GROUPS && (val >> (GROUP_W * n)) != 0) n++;
      for (int g = n - 1; g >= 0; g--) begin
        grp = 8'(val >> (GROUP_W * g)) & GROUP_MASK;
        if (g != 0) grp = grp | CONT_BIT;
        arc_bytes_q.insert(arc_bytes_q.size(), oid_byte_t'{grp, g == 0, 1'b0});
      end
      enc_pos = l ? POS_FIRST : POS_BODY;
      if (l) enc_first = '0;
    end
  endtask

  // Monitor: predict on every accepted request, check every accepted byte.
  always @(posedge clk) begin
    oid_byte_t got;
    oid_byte_t want;
    if (rst) begin
      enc_pos = POS_FIRST;
      enc_first = '0;
    end else begin
      if (push && !full) begin
        arc_bytes_q.delete();
        encode_arc(arc_value, first_of_oid, last_of_oid);
        if (row_typed) begin
          for (int k = 0; k < row_cnt; k++)
            oid_bytes_q.insert(oid_bytes_q.size(),
                               oid_byte_t'{row_bytes[8 * (row_cnt - 1 - k) +: 8],
                                           !row_bad && (k == row_cnt - 1), row_bad});
        end else begin
          foreach (arc_bytes_q[k]) oid_bytes_q.insert(oid_bytes_q.size(), arc_bytes_q[k]);
        end
      end
      if (pop && !empty) begin
        got = '{out_byte, arc_done, bad_oid};
        n_bytes++;
        if (bad_oid) n_errors++;
        if (oid_bytes_q.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h done=%b bad=%b",
                                    out_byte, arc_done, bad_oid));
        end else begin
          want = oid_bytes_q.pop_front();
          if (got.data !== want.data)
            report_mismatch($sformatf("out_byte %02h, want %02h", got.data, want.data));
          if (got.done !== want.done)
            report_mismatch($sformatf("arc_done %b, want %b", got.done, want.done));
          if (got.bad !== want.bad)
            report_mismatch($sformatf("bad_oid %b, want %b", got.bad, want.bad));
        end
      end
    end
  end

  // Result side: random stalls, with stretches of steady popping.
  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) rx_quiet <= !rx_quiet;
    if (rx_hold != 0) begin
      pop <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else begin
      pop <= 1'b1;
      if (!rx_quiet && $urandom_range(0, 3) == 0) rx_hold <= gap_len();
    end
  end

  // Present one request and hold it until accepted.
  task automatic send_arc(input logic [31:0] arc, input logic f, input logic l,
                          input logic typed, input logic [2:0] cnt, input logic bad,
                          input logic [39:0] bytes);
    if (!tx_quiet && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat (gap_len()) @(posedge clk);
    end
    push <= 1'b1;
    arc_value <= arc;
    first_of_oid <= f;
    last_of_oid <= l;
    row_typed <= typed;
    row_cnt <= cnt;
    row_bad <= bad;
    row_bytes <= bytes;
    do @(posedge clk); while (full);
    n_sent++;
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    do @(negedge clk); while (oid_bytes_q.size() != 0);
    @(posedge clk);
  endtask

  // Append one row to the directed table.
  task automatic add_row(input arc_row_t r);
    dir_tab.insert(dir_tab.size(), r);
  endtask

  initial begin
    int       len;
    int       kind;
    bit       paused;
    logic [31:0] v;
    logic        f;
    logic        l;

    // after reset
    add_row('{32'd0, 1'b1, 1'b0, CHK_TYPED, 3'd0, 1'b0, 40'h0});
    add_row('{32'd0, 1'b0, 1'b1, CHK_TYPED, 3'd1, 1'b0, 40'h00});
    // largest combined first value
    add_row('{32'd2, 1'b1, 1'b0, CHK_TYPED, 3'd0, 1'b0, 40'h0});
    add_row('{32'hFFFF_FFFF, 1'b0, 1'b1, CHK_PREDICT, 3'd0, 1'b0, 40'h0});
    // group boundaries in the body
    add_row('{32'd1, 1'b1, 1'b0, CHK_TYPED, 3'd0, 1'b0, 40'h0});
    add_row('{32'd39, 1'b0, 1'b0, CHK_PREDICT, 3'd0, 1'b0, 40'h0});
    add_row('{32'd127, 1'b0, 1'b0, CHK_TYPED, 3'd1, 1'b0, 40'h7F});
    add_row('{32'd128, 1'b0, 1'b0, CHK_TYPED, 3'd2, 1'b0, 40'h8100});
    add_row('{32'hFFFF_FFFF, 1'b0, 1'b1, CHK_TYPED, 3'd5, 1'b0, 40'h8FFFFFFF7F});
    // first arc above 2, alone and followed by discarded arcs
    add_row('{32'd3, 1'b1, 1'b1, CHK_TYPED, 3'd1, 1'b1, 40'h0});
    add_row('{32'hFFFF_FFFF, 1'b1, 1'b0, CHK_TYPED, 3'd1, 1'b1, 40'h0});
    add_row('{32'd5, 1'b0, 1'b0, CHK_TYPED, 3'd0, 1'b0, 40'h0});
    add_row('{32'd7, 1'b0, 1'b1, CHK_TYPED, 3'd0, 1'b0, 40'h0});
    // one-arc OIDs, with and without the first mark
    add_row('{32'd1, 1'b0, 1'b1, CHK_TYPED, 3'd1, 1'b1, 40'h0});
    add_row('{32'd2, 1'b1, 1'b1, CHK_TYPED, 3'd1, 1'b1, 40'h0});
    // restart mid-OID, then a restart out of the discard state
    add_row('{32'd0, 1'b1, 1'b0, CHK_TYPED, 3'd0, 1'b0, 40'h0});
    add_row('{32'd5, 1'b1, 1'b0, CHK_TYPED, 3'd1, 1'b1, 40'h0});
    add_row('{32'd2, 1'b1, 1'b0, CHK_TYPED, 3'd0, 1'b0, 40'h0});
    add_row('{32'd3, 1'b0, 1'b0, CHK_PREDICT, 3'd0, 1'b0, 40'h0});
    add_row('{32'd300, 1'b0, 1'b0, CHK_PREDICT, 3'd0, 1'b0, 40'h0});
    add_row('{32'd16383, 1'b0, 1'b0, CHK_PREDICT, 3'd0, 1'b0, 40'h0});
    add_row('{32'd16384, 1'b0, 1'b1, CHK_PREDICT, 3'd0, 1'b0, 40'h0});
    // restart from inside the body with a one-arc OID
    add_row('{32'd1, 1'b1, 1'b0, CHK_TYPED, 3'd0, 1'b0, 40'h0});
    add_row('{32'd1, 1'b0, 1'b0, CHK_PREDICT, 3'd0, 1'b0, 40'h0});
    add_row('{32'd0, 1'b1, 1'b1, CHK_TYPED, 3'd1, 1'b1, 40'h0});

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i])
      send_arc(dir_tab[i].arc, dir_tab[i].first, dir_tab[i].last, dir_tab[i].typed,
               dir_tab[i].cnt, dir_tab[i].bad, dir_tab[i].bytes);
    wait_drained();

    paused = 1'b0;
    while (n_sent < dir_tab.size() + N_RANDOM) begin
      tx_quiet = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        // well-formed OID with random content
        len = $urandom_range(2, 7);
        for (int a = 0; a < len; a++) begin
          v = (a == 0) ? 32'($urandom_range(0, MAX_FIRST_ARC)) : rand_arc();
          send_arc(v, a == 0, a == len - 1, CHK_PREDICT, 3'd0, 1'b0, 40'h0);
        end
      end else if (kind < 9) begin
        // broken OID: bad first arc, stray restarts, missing end
        len = $urandom_range(1, 4);
        for (int a = 0; a < len; a++) begin
          v = ($urandom_range(0, 1) != 0) ? rand_arc() : 32'($urandom_range(0, 4));
          f = (a == 0) || ($urandom_range(0, 3) == 0);
          l = (a == len - 1) && ($urandom_range(0, 2) != 0);
          send_arc(v, f, l, CHK_PREDICT, 3'd0, 1'b0, 40'h0);
        end
      end else begin
        send_arc($urandom, 1'($urandom), 1'($urandom), CHK_PREDICT, 3'd0, 1'b0, 40'h0);
      end
      // hold the input once until every byte in flight has come out
      if (!paused && n_sent >= dir_tab.size() + N_RANDOM / 2) begin
        paused = 1'b1;
        wait_drained();
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d arcs (%0d directed, rest random OIDs and broken sequences),",
             n_sent, dir_tab.size());
    $display("checked %0d output bytes, %0d of them error results, under random stalls.",
             n_bytes, n_errors);
    if (n_mismatch == 0 && oid_bytes_q.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

[oid_arc_base128_encoder_top.f]
rtl/oab_pkg.sv
rtl/oab_front.sv
rtl/oab_cmd_fifo.sv
rtl/oab_back.sv
rtl/oid_arc_base128_encoder_top.sv
tb/tb_oid_arc_base128_encoder_top.sv
